// File: design/gray_world_rgb_white_balance_core_defines.svh
// Assertion macros for the gray-world white balance core.
// Included by the top level; depends on nothing else.
`ifndef GRAY_WORLD_RGB_WHITE_BALANCE_CORE_DEFINES_SVH
`define GRAY_WORLD_RGB_WHITE_BALANCE_CORE_DEFINES_SVH

// Check that a condition implies a consequence on the same edge.
`define GW_ASSERT_NOW(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence on the next edge.
`define GW_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);

`endif

// File: design/gwwb_pkg.sv
// Shared types and constants for the gray-world white balance core.
// No dependencies.
`timescale 1ns / 1ps
package gwwb_pkg;
   localparam int SUM_W  = 30;
   localparam int GAIN_W = 24;
   localparam int PIX_W  = 8;
   localparam int TOT_W  = SUM_W + 2;

   // one beat as it sits in the queue between front and back
   typedef struct packed {
      logic             mode;
      logic             first;
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } beat_type;

   typedef enum logic [3:0] {
      ST_RUN    = 4'b0001,
      ST_DIVIDE = 4'b0010,
      ST_MUL    = 4'b0100,
      ST_OUT    = 4'b1000
   } back_state_type;
endpackage

// File: design/gray_world_rgb_white_balance_core.sv
// Channel  | Dir | Handshake           | Payload
// req_     | in  | req_valid/req_stall | req_mode req_first req_blue req_green req_red
// rsp_     | out | rsp_valid/rsp_stall | rsp_out_blue rsp_out_green rsp_out_red
// A gather beat is summed in the run state of the back part; a correct beat
// passes through capture, multiply and round before its result registers.
// The first correct beat after gathering waits while the shared
// one-bit-per-cycle gain divider computes all three gains. Reset is
// synchronous, active high, and clears sums, gains and queue. A two-entry
// queue lets the front accept up to two beats while the back stalls on rsp_stall.
`timescale 1ns / 1ps
`include "gray_world_rgb_white_balance_core_defines.svh"
module gray_world_rgb_white_balance_core
   import gwwb_pkg::*;
#(
   parameter int PIXEL_LIMIT        = 4194304,
   parameter int GAIN_FRACTION_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic             req_mode,
   input  logic             req_first,
   input  logic [PIX_W-1:0] req_blue,
   input  logic [PIX_W-1:0] req_green,
   input  logic [PIX_W-1:0] req_red,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [PIX_W-1:0] rsp_out_blue,
   output logic [PIX_W-1:0] rsp_out_green,
   output logic [PIX_W-1:0] rsp_out_red
);
   beat_type q_in, q_out;
   logic     q_valid, q_take, ready;

   // pack the request beat
   assign q_in = '{mode: req_mode, first: req_first, blue: req_blue,
                   green: req_green, red: req_red};

   gwwb_queue u_queue (
      .clock(clock), .reset(reset), .wr_valid(req_valid), .wr_stall(req_stall),
      .wr_data(q_in), .rd_valid(q_valid), .rd_take(q_take), .rd_data(q_out)
   );

   gwwb_back #(.PIXEL_LIMIT(PIXEL_LIMIT), .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)) u_back (
      .clock(clock), .reset(reset), .in_valid(q_valid), .in_take(q_take),
      .in_data(q_out), .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_blue(rsp_out_blue), .out_green(rsp_out_green), .out_red(rsp_out_red),
      .gains_ready(ready)
   );

   `GW_ASSERT_NOW(a_take_valid, clock, reset, q_take, q_valid, "take without queued beat")
   `GW_ASSERT_NOW(a_correct_ready, clock, reset, q_take && q_out.mode, ready,
                  "correct beat taken before gains ready")
   `GW_ASSERT_NEXT(a_gather_clears, clock, reset, q_take && !q_out.mode, !ready,
                   "gather beat left gains ready")
endmodule

// File: design/gwwb_queue.sv
// Two-entry queue between the front and back parts.
// Depends on gwwb_pkg.
`timescale 1ns / 1ps
module gwwb_queue
   import gwwb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_valid,
   output logic     wr_stall,
   input  beat_type wr_data,
   output logic     rd_valid,
   input  logic     rd_take,
   output beat_type rd_data
);
   beat_type   mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign wr_stall = (cnt_ff == 2'd2);
   assign rd_valid = (cnt_ff != 2'd0);
   assign rd_data  = mem_ff[rptr_ff];
   assign push     = wr_valid && !wr_stall;
   assign pop      = rd_take && rd_valid;

   // store entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         if (push) wptr_ff <= !wptr_ff;
         if (pop)  rptr_ff <= !rptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

// File: design/gwwb_divider.sv
// Restoring divider, one quotient bit per cycle, for gain computation.
// Depends on gwwb_pkg.
`timescale 1ns / 1ps
module gwwb_divider
   import gwwb_pkg::*;
#(
   parameter int NUM_W = 56,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);
   logic [NUM_W-1:0] q_ff;
   logic [DEN_W:0]   rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;

   assign trial = {rem_ff[DEN_W-1:0], q_ff[NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign done  = done_ff;
   assign quot  = q_ff;

   // shift one bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff   <= numer;
         rem_ff <= '0;
         den_ff <= denom;
      end else if (busy_ff) begin
         if (!diff[DEN_W]) begin
            rem_ff <= diff;
            q_ff   <= {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial;
            q_ff   <= {q_ff[NUM_W-2:0], 1'b0};
         end
      end
   end
endmodule

// File: design/gwwb_back.sv
// Back part: gathers sums, computes gains, applies them to pixels.
// Depends on gwwb_pkg and gwwb_divider.
`timescale 1ns / 1ps
module gwwb_back
   import gwwb_pkg::*;
#(
   parameter int PIXEL_LIMIT        = 4194304,
   parameter int GAIN_FRACTION_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_take,
   input  beat_type         in_data,
   output logic             out_valid,
   input  logic             out_stall,
   output logic [PIX_W-1:0] out_blue,
   output logic [PIX_W-1:0] out_green,
   output logic [PIX_W-1:0] out_red,
   output logic             gains_ready
);
   localparam logic [39:0] CAP_RAW = 40'(PIXEL_LIMIT) * 40'd255;
   localparam logic [SUM_W-1:0] SUM_CAP =
      (CAP_RAW > 40'h3FFFFFFF) ? SUM_W'(30'h3FFFFFFF) : SUM_W'(CAP_RAW);
   localparam int NUM_W  = TOT_W + GAIN_FRACTION_BITS;
   localparam int DEN_W  = SUM_W + 2;
   localparam int PROD_W = PIX_W + GAIN_W;

   logic [SUM_W-1:0]  sum_ff [3];
   logic [GAIN_W-1:0] gain_ff [3];
   logic              ready_ff;
   back_state_type    state_ff;
   logic [1:0]        ch_ff;
   logic              dstart_ff;
   logic [PROD_W-1:0] prod_ff [3];
   logic [PIX_W-1:0]  pix_ff [3];
   logic [PIX_W-1:0]  res_ff [3];
   logic              ovalid_ff;
   logic [SUM_W-1:0]  base [3];
   logic [SUM_W:0]    add [3];
   logic [TOT_W-1:0]  total;
   logic [SUM_W-1:0]  cur_sum;
   logic [DEN_W-1:0]  den;
   logic [NUM_W-1:0]  numer, quot;
   logic              ddone;
   logic [PIX_W-1:0]  pixv [3];

   assign pixv[0] = in_data.blue;
   assign pixv[1] = in_data.green;
   assign pixv[2] = in_data.red;

   assign total   = TOT_W'(sum_ff[0]) + TOT_W'(sum_ff[1]) + TOT_W'(sum_ff[2]);
   assign cur_sum = sum_ff[ch_ff];
   assign den     = DEN_W'(cur_sum) + (DEN_W'(cur_sum) << 1);
   assign numer   = (NUM_W'(total) << GAIN_FRACTION_BITS) + NUM_W'(den >> 1);

   gwwb_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
      .clock(clock), .reset(reset), .start(dstart_ff),
      .numer(numer), .denom(den), .done(ddone), .quot(quot)
   );

   // in the run state, take a gather beat at once; a correct beat once gains are ready and the output slot frees
   always_comb begin
      in_take = 1'b0;
      if (state_ff == ST_RUN && in_valid) begin
         if (!in_data.mode) in_take = 1'b1;
         else if (ready_ff) in_take = !ovalid_ff || !out_stall;
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_ch
      assign base[c] = in_data.first ? '0 : sum_ff[c];
      assign add[c]  = {1'b0, base[c]} + (SUM_W+1)'(pixv[c]);
   end

   // sequence gather, gain division and pixel scaling
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_RUN;
         ready_ff  <= 1'b0;
         ch_ff     <= '0;
         dstart_ff <= 1'b0;
         ovalid_ff <= 1'b0;
         for (int c = 0; c < 3; c++) begin
            sum_ff[c]  <= '0;
            gain_ff[c] <= '0;
         end
      end else begin
         dstart_ff <= 1'b0;
         if (ovalid_ff && !out_stall) ovalid_ff <= 1'b0;
         case (state_ff)
            ST_RUN: begin
               if (in_valid && !in_data.mode) begin
                  for (int c = 0; c < 3; c++) begin
                     sum_ff[c] <= (add[c] > (SUM_W+1)'(SUM_CAP)) ? SUM_CAP
                                                                : add[c][SUM_W-1:0];
                  end
                  ready_ff <= 1'b0;
               end else if (in_valid && !ready_ff) begin
                  ch_ff     <= '0;
                  dstart_ff <= 1'b1;
                  state_ff  <= ST_DIVIDE;
               end else if (in_take) begin
                  state_ff <= ST_MUL;
               end
            end
            ST_DIVIDE: begin
               if (ddone) begin
                  if (cur_sum == '0) gain_ff[ch_ff] <= '0;
                  else if (|quot[NUM_W-1:GAIN_W]) gain_ff[ch_ff] <= '1;
                  else gain_ff[ch_ff] <= quot[GAIN_W-1:0];
                  if (ch_ff == 2'd2) begin
                     ready_ff <= 1'b1;
                     state_ff <= ST_RUN;
                  end else begin
                     ch_ff     <= ch_ff + 2'd1;
                     dstart_ff <= 1'b1;
                  end
               end
            end
            ST_MUL: state_ff <= ST_OUT;
            ST_OUT: begin
               ovalid_ff <= 1'b1;
               state_ff  <= ST_RUN;
            end
            default: state_ff <= ST_RUN;
         endcase
      end
   end

   // pixel datapath: capture, multiply, round and saturate
   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         if (in_take) pix_ff[c] <= pixv[c];
         if (state_ff == ST_MUL) prod_ff[c] <= PROD_W'(pix_ff[c]) * PROD_W'(gain_ff[c]);
         if (state_ff == ST_OUT) begin
            if (|((prod_ff[c] + (PROD_W'(1) << (GAIN_FRACTION_BITS-1)))
                  >> (GAIN_FRACTION_BITS+PIX_W)))
               res_ff[c] <= '1;
            else
               res_ff[c] <= PIX_W'((prod_ff[c] + (PROD_W'(1) << (GAIN_FRACTION_BITS-1)))
                                   >> GAIN_FRACTION_BITS);
         end
      end
   end

   assign out_valid   = ovalid_ff;
   assign out_blue    = res_ff[0];
   assign out_green   = res_ff[1];
   assign out_red     = res_ff[2];
   assign gains_ready = ready_ff;
endmodule
